// ----- src/checksummed_frame_receiver_top_defines.svh -----
// Assertion macros shared by the frame receiver modules.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef CHECKSUMMED_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_TOP_DEFINES_SVH

// Check a condition at every edge outside reset.
`define CFR_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define CFR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/cfr_pkg.sv -----
package cfr_pkg;

   typedef logic [7:0] byte_type;

   localparam byte_type FrameHeader  = 8'hA5;
   localparam byte_type FrameTrailer = 8'h5A;

   // Payload length: legal range 1..64
   localparam int PayloadLenDefault = 8;

   // Result handed from the parser to the output register
   typedef struct packed {
      logic     frame_ok;
      byte_type mode_value;
   } result_type;

endpackage

// ----- src/cfr_if.sv -----
interface cfr_req_if;
   logic             valid;
   logic             ready;
   cfr_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic             valid;
   logic             ready;
   logic             frame_ok;
   cfr_pkg::byte_type mode_value;

   modport source (output valid, output frame_ok, output mode_value, input ready);
   modport sink   (input valid, input frame_ok, input mode_value, output ready);
endinterface

// ----- src/cfr_parser.sv -----
`include "checksummed_frame_receiver_top_defines.svh"

module cfr_parser #(
   parameter int PayloadLen = cfr_pkg::PayloadLenDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  cfr_pkg::byte_type  rx_byte,
   output logic               result_valid,
   output cfr_pkg::result_type result
);

   localparam int CountW = $clog2(PayloadLen + 1);
   localparam logic [CountW-1:0] CountLast = CountW'(PayloadLen);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_PAYLOAD,
      PH_CHECK,
      PH_TRAILER
   } phase_type;

   phase_type         phase_ff;
   logic [CountW-1:0] count_ff;
   cfr_pkg::byte_type sum_ff;
   cfr_pkg::byte_type first_ff;
   cfr_pkg::byte_type rxsum_ff;

   logic [CountW-1:0] count_in;
   cfr_pkg::byte_type sum_in;

   assign count_in = count_ff + CountW'(1);
   assign sum_in   = sum_ff + rx_byte;

   // Result leaves on the trailer byte only
   assign result_valid      = step && (phase_ff == PH_TRAILER);
   assign result.frame_ok   = (rxsum_ff == sum_ff) && (rx_byte == cfr_pkg::FrameTrailer);
   assign result.mode_value = first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         sum_ff   <= '0;
         first_ff <= '0;
         rxsum_ff <= '0;
      end else if (step) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == cfr_pkg::FrameHeader) begin
                  phase_ff <= PH_PAYLOAD;
                  count_ff <= '0;
                  sum_ff   <= '0;
               end
            end
            PH_PAYLOAD: begin
               if (count_ff == '0) begin
                  first_ff <= rx_byte;
               end
               sum_ff   <= sum_in;
               count_ff <= count_in;
               if (count_in == CountLast) begin
                  phase_ff <= PH_CHECK;
               end
            end
            PH_CHECK: begin
               rxsum_ff <= rx_byte;
               phase_ff <= PH_TRAILER;
            end
            default: begin
               // Good or bad, drop back to hunting
               phase_ff <= PH_HUNT;
               count_ff <= '0;
               sum_ff   <= '0;
            end
         endcase
      end
   end

   `CFR_ASSERT_ALWAYS(a_count_bound, count_ff <= CountLast, "payload count past frame length")
   `CFR_ASSERT_ALWAYS(a_hunt_clear, (phase_ff != PH_HUNT) || (count_ff == '0 && sum_ff == '0), "hunt entered with stale count or sum")
   `CFR_ASSERT_NEXT(a_trailer_ends, step && phase_ff == PH_TRAILER, phase_ff == PH_HUNT, "frame did not end at trailer")

endmodule

// ----- src/checksummed_frame_receiver_top.sv -----
// Flow: a byte accepted into the input register is parsed once the output register can
//   take a result; that result, if any, is registered there, and that register drives rsp valid.
// Throughput: one byte per cycle while the rsp sink keeps up; a result waiting on rsp
//   holds every byte behind it in the input register.
// Reset: synchronous, active high; empties both registers and restarts header hunt.
`include "checksummed_frame_receiver_top_defines.svh"

module checksummed_frame_receiver_top #(
   parameter int PayloadLen = cfr_pkg::PayloadLenDefault
) (
   input logic       clock,
   input logic       reset,
   cfr_req_if.sink   req_if,
   cfr_rsp_if.source rsp_if
);

   // Input register: holds one received transaction ahead of the parser
   logic              in_valid_ff;
   logic              in_valid_in;
   cfr_pkg::byte_type in_byte_ff;

   // Output register: holds one finished result until the sink takes it
   logic                out_valid_ff;
   logic                out_valid_in;
   cfr_pkg::result_type out_ff;

   logic                step;
   logic                result_valid;
   cfr_pkg::result_type result;
   logic                req_take;

   // Advance the held byte whenever the output register can absorb a result.
   // A byte that yields no result still waits here, which keeps the order simple.
   assign step     = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   // Accept a new transaction when the input register is empty or empties this cycle
   assign req_if.ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && result_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   cfr_parser #(
      .PayloadLen (PayloadLen)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_if.rx_byte;
      end
      if (step && result_valid) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.frame_ok   = out_ff.frame_ok;
   assign rsp_if.mode_value = out_ff.mode_value;

   `CFR_ASSERT_NEXT(a_take_fills, req_take, in_valid_ff, "accepted byte not held")
   `CFR_ASSERT_NEXT(a_hold_byte, in_valid_ff && !step, in_valid_ff && $stable(in_byte_ff), "waiting byte lost")
   `CFR_ASSERT_NEXT(a_result_kept, out_valid_ff && !rsp_if.ready, out_valid_ff && $stable(out_ff), "waiting result lost")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   // Payload length of the block under test; the parser model follows the same value.
   localparam int PayloadLen = cfr_pkg::PayloadLenDefault;

   // End the run after this many cycles with no transaction on either channel.
   // The long receiver hold-off below is well inside it.
   localparam int WatchdogLimit = 5000;
   localparam int LongHoldCycles = 400;

   // Cycles allowed after the last result for anything stray to surface.
   localparam int DrainCycles = 20;

   localparam int MaxReported = 10;

   typedef enum logic [1:0] {
      HUNT     = 2'd0,
      PAYLOAD  = 2'd1,
      CHECKSUM = 2'd2,
      TRAILER  = 2'd3
   } parse_phase_type;

   logic clock;
   logic reset;

   cfr_req_if req_if ();
   cfr_rsp_if rsp_if ();

   checksummed_frame_receiver_top #(
      .PayloadLen(PayloadLen)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // Parser model state, mirrored from the frame format.
   parse_phase_type   parse_phase;
   logic [6:0]        pay_count;
   cfr_pkg::byte_type sum_acc;
   cfr_pkg::byte_type first_byte;
   cfr_pkg::byte_type sum_rx;

   // Frame verdicts still owed by the block, oldest first.
   cfr_pkg::result_type pending_results[$];

   int  mismatch_count;
   int  bytes_sent;
   bit  sender_idle_en;
   bit  receiver_stall_en;
   int  hold_requests;
   int  quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the parser model by one accepted byte; queue a verdict at the trailer.
   function automatic void parse_rx_byte(input cfr_pkg::byte_type b);
      cfr_pkg::result_type verdict;
      case (parse_phase)
         HUNT: begin
            // Drop everything but the header while hunting.
            if (b == cfr_pkg::FrameHeader) begin
               parse_phase = PAYLOAD;
               pay_count   = '0;
               sum_acc     = '0;
            end
         end
         PAYLOAD: begin
            if (pay_count == 0)
               first_byte = b;
            sum_acc   = sum_acc + b;
            pay_count = pay_count + 7'd1;
            if (pay_count >= PayloadLen)
               parse_phase = CHECKSUM;
         end
         CHECKSUM: begin
            sum_rx      = b;
            parse_phase = TRAILER;
         end
         default: begin
            // The trailer byte is consumed here, even when it happens to be a header.
            verdict.frame_ok   = (sum_rx == sum_acc) && (b == cfr_pkg::FrameTrailer);
            verdict.mode_value = first_byte;
            pending_results.push_back(verdict);
            parse_phase = HUNT;
            pay_count   = '0;
            sum_acc     = '0;
         end
      endcase
   endfunction

   // Offer one byte and hold it until the block takes it.
   task automatic send_byte(input cfr_pkg::byte_type b);
      if (sender_idle_en && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      parse_rx_byte(b);
      bytes_sent++;
   endtask

   // Send header, payload, checksum and trailer; spoil the checksum on request.
   task automatic send_frame(input cfr_pkg::byte_type body [PayloadLen], input bit sum_good,
                             input cfr_pkg::byte_type trailer);
      cfr_pkg::byte_type sum;
      sum = '0;
      send_byte(cfr_pkg::FrameHeader);
      for (int i = 0; i < PayloadLen; i++) begin
         sum = sum + body[i];
         send_byte(body[i]);
      end
      if (!sum_good)
         sum = sum + cfr_pkg::byte_type'($urandom_range(1, 255));
      send_byte(sum);
      send_byte(trailer);
   endtask

   // Mostly well-formed frames with random content; the rest carry stray bytes
   // between frames, spoilt checksums or wrong trailers.
   task automatic send_random_frame();
      cfr_pkg::byte_type body [PayloadLen];
      cfr_pkg::byte_type trailer;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(cfr_pkg::byte_type'($urandom_range(0, 255)));
      end
      for (int i = 0; i < PayloadLen; i++) begin
         case ($urandom_range(0, 9))
            0:       body[i] = cfr_pkg::FrameHeader;
            1:       body[i] = 8'h00;
            2:       body[i] = 8'hFF;
            default: body[i] = cfr_pkg::byte_type'($urandom_range(0, 255));
         endcase
      end
      case ($urandom_range(0, 19))
         0:       trailer = cfr_pkg::FrameHeader;
         1, 2:    trailer = cfr_pkg::byte_type'($urandom_range(0, 255));
         default: trailer = cfr_pkg::FrameTrailer;
      endcase
      send_frame(body, $urandom_range(0, 4) != 0, trailer);
   endtask

   // Stray bytes, then one good frame with extreme payload values and a header
   // byte inside the payload, then a frame whose trailer is a header byte.
   task automatic test_directed_frames();
      cfr_pkg::byte_type body [PayloadLen];
      send_byte(8'h00);
      send_byte(8'hFF);
      for (int i = 0; i < PayloadLen; i++) begin
         case (i % 8)
            0: body[i] = 8'hFF;
            1: body[i] = cfr_pkg::FrameHeader;
            2: body[i] = 8'h00;
            3: body[i] = 8'h80;
            4: body[i] = 8'h01;
            5: body[i] = 8'h7F;
            6: body[i] = cfr_pkg::FrameTrailer;
            default: body[i] = 8'hFE;
         endcase
      end
      send_frame(body, 1'b1, cfr_pkg::FrameTrailer);
      for (int i = 0; i < PayloadLen; i++)
         body[i] = cfr_pkg::byte_type'(8'h00 + i);
      // The bad trailer must not restart a frame: the parser hunts again afterwards.
      send_frame(body, 1'b1, cfr_pkg::FrameHeader);
   endtask

   task automatic test_random_traffic();
      sender_idle_en    = 1'b1;
      receiver_stall_en = 1'b1;
      while (bytes_sent < 900)
         send_random_frame();
   endtask

   // Hold the receiver off for a long stretch while frames keep streaming in,
   // so that the result stage fills and the block stalls its input.
   task automatic test_backpressure();
      sender_idle_en = 1'b0;
      hold_requests++;
      repeat (6) send_random_frame();
   endtask

   // Finish with back-to-back traffic and no idling on either side.
   task automatic test_streaming();
      sender_idle_en    = 1'b0;
      receiver_stall_en = 1'b0;
      while (bytes_sent < 1300)
         send_random_frame();
   endtask

   // Receiver: take results freely, stall in random bursts, or hold off for the
   // long stretch each time a test asks for one.
   initial begin
      int holds_taken;
      holds_taken = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_taken) begin
            holds_taken  = hold_requests;
            rsp_if.ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end else if (receiver_stall_en && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every accepted result with the oldest verdict still owed.
   always @(posedge clock) begin
      cfr_pkg::result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
               $display("result with none expected: ok=%0b mode=%02h",
                        rsp_if.frame_ok, rsp_if.mode_value);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.frame_ok !== want.frame_ok || rsp_if.mode_value !== want.mode_value)
            begin
               mismatch_count++;
               if (mismatch_count <= MaxReported)
                  $display("result mismatch: expected ok=%0b mode=%02h, got ok=%0b mode=%02h",
                           want.frame_ok, want.mode_value,
                           rsp_if.frame_ok, rsp_if.mode_value);
            end
         end
      end
   end

   // Count cycles without any transaction; give up once the limit is reached.
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      parse_phase       = HUNT;
      pay_count         = '0;
      sum_acc           = '0;
      first_byte        = '0;
      sum_rx            = '0;
      mismatch_count    = 0;
      bytes_sent        = 0;
      sender_idle_en    = 1'b0;
      receiver_stall_en = 1'b0;
      hold_requests     = 0;

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_random_traffic();
      test_backpressure();
      test_streaming();

      req_if.valid <= 1'b0;
      // Wait for every owed verdict; the watchdog catches a block that never answers.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
